// ===== design/gbr_pkg.sv =====
// Shared types and constants for the gain grid bilinear resampler.
// Used by every module of the block but gbr_ram; depends on nothing.
package gbr_pkg;

    // Index widths: up to 64 entries per axis and 4096 addresses
    localparam int unsigned IDX_W  = 6;
    localparam int unsigned ADDR_W = 12;

    // Weight of one full step in the 16-bit fraction
    localparam logic [16:0] FRAC_ONE = 17'h10000;

    // Request codes
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_X_START = 3'd0;
    localparam logic [2:0] REG_X_STEP  = 3'd1;
    localparam logic [2:0] REG_Y_START = 3'd2;
    localparam logic [2:0] REG_Y_STEP  = 3'd3;
    localparam logic [2:0] REG_FLIP_H  = 3'd4;
    localparam logic [2:0] REG_FLIP_V  = 3'd5;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  entry_index;
        logic [15:0] entry_value;
        logic [3:0]  out_col;
        logic [3:0]  out_row;
    } t_in_item;

    typedef struct packed {
        logic [15:0] sample_value;
        logic [7:0]  sample_index;
    } t_out_item;

    typedef struct packed {
        logic [23:0] x_start;
        logic [20:0] x_step;
        logic [23:0] y_start;
        logic [20:0] y_step;
        logic        flip_horizontal;
        logic        flip_vertical;
    } t_cfg;

    // One classified command between front and back
    typedef struct packed {
        logic              is_load;
        logic [ADDR_W-1:0] addr_a;   // load address, or (row lo, col lo)
        logic [ADDR_W-1:0] addr_b;   // (row lo, col hi)
        logic [ADDR_W-1:0] addr_c;   // (row hi, col lo)
        logic [ADDR_W-1:0] addr_d;   // (row hi, col hi)
        logic [15:0]       value;
        logic [15:0]       frac_x;
        logic [15:0]       frac_y;
        logic [7:0]        sample_index;
    } t_cmd;

    // Back end sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RD1,
        BK_RD2,
        BK_RD3
    } t_bk_state;

    // Which neighbor a read returns
    typedef enum logic [1:0] {
        TAP_A,
        TAP_B,
        TAP_C,
        TAP_D
    } t_tap;

endpackage

// ===== design/gbr_ram.sv =====
// Generic single-port RAM, one write or one read per cycle, registered read.
// No dependencies.
module gbr_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/gbr_queue.sv =====
// Two-entry command queue between the front and the back end.
// Depends on gbr_pkg for the command type.
module gbr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gbr_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output gbr_pkg::t_cmd o_cmd
);
    import gbr_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_slot[r_rp];

    // pointer and fill update
    always_comb begin
        n_wp  = r_wp ^ i_push;
        n_rp  = r_rp ^ i_pop;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== design/gbr_front.sv =====
// Front end: accepts items, forms sample positions, clamps and mirrors the
// neighbor indices and hands classified commands to the queue. Uses gbr_pkg.
module gbr_front #(
    parameter int unsigned GRID_WIDTH  = 16,
    parameter int unsigned GRID_HEIGHT = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gbr_pkg::t_cfg     i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  gbr_pkg::t_in_item i_in_data,
    output logic              o_push,
    output gbr_pkg::t_cmd     o_cmd,
    input  logic              i_q_full
);
    import gbr_pkg::*;

    localparam int unsigned CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam logic signed [11:0] X_LIM = 12'(GRID_WIDTH - 1);
    localparam logic signed [11:0] Y_LIM = 12'(GRID_HEIGHT - 1);

    // clamp a signed table index into 0..lim
    function automatic logic [IDX_W-1:0] clamp_idx(input logic signed [11:0] v,
                                                   input logic signed [11:0] lim);
        logic [IDX_W-1:0] res;
        if (v < 12'sd0) begin
            res = '0;
        end else if (v > lim) begin
            res = lim[IDX_W-1:0];
        end else begin
            res = v[IDX_W-1:0];
        end
        return res;
    endfunction

    // stage A: positions in signed Q11.16
    logic               r_a_valid;
    t_in_item           r_a_item;
    logic signed [26:0] r_a_x;
    logic signed [26:0] r_a_y;
    logic               a_load;
    logic               consume;
    logic               drop;
    logic               in_accept;
    logic [24:0]        x_prod;
    logic [24:0]        y_prod;
    logic [26:0]        x_pos;
    logic [26:0]        y_pos;

    assign x_prod = 25'(i_in_data.out_col) * 25'(i_cfg.x_step);
    assign y_prod = 25'(i_in_data.out_row) * 25'(i_cfg.y_step);
    assign x_pos  = {{3{i_cfg.x_start[23]}}, i_cfg.x_start} + {2'b00, x_prod};
    assign y_pos  = {{3{i_cfg.y_start[23]}}, i_cfg.y_start} + {2'b00, y_prod};

    // stage A advances when empty or when its item leaves
    assign a_load     = (r_a_item.req_type == REQ_LOAD);
    assign drop       = a_load && ({5'd0, r_a_item.entry_index} >= 13'(CELLS));
    assign consume    = r_a_valid && (drop || !i_q_full);
    assign o_in_stall = r_a_valid && !consume;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_accept) begin
            r_a_valid <= 1'b1;
        end else if (consume) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_item <= i_in_data;
            r_a_x    <= $signed(x_pos);
            r_a_y    <= $signed(y_pos);
        end
    end

    // stage B: neighbors, mirroring and addresses
    logic signed [11:0] x_fl, y_fl;
    logic [IDX_W-1:0]   xl, xh, yl, yh;
    logic [IDX_W-1:0]   xl_c, xh_c, yl_c, yh_c;
    logic [ADDR_W-1:0]  cell_idx;

    assign x_fl = {r_a_x[26], r_a_x[26:16]};
    assign y_fl = {r_a_y[26], r_a_y[26:16]};

    always_comb begin
        xl_c = clamp_idx(x_fl, X_LIM);
        xh_c = clamp_idx(x_fl + 12'sd1, X_LIM);
        yl_c = clamp_idx(y_fl, Y_LIM);
        yh_c = clamp_idx(y_fl + 12'sd1, Y_LIM);
        if (i_cfg.flip_horizontal) begin
            xl = X_LIM[IDX_W-1:0] - xl_c;
            xh = X_LIM[IDX_W-1:0] - xh_c;
        end else begin
            xl = xl_c;
            xh = xh_c;
        end
        if (i_cfg.flip_vertical) begin
            yl = Y_LIM[IDX_W-1:0] - yl_c;
            yh = Y_LIM[IDX_W-1:0] - yh_c;
        end else begin
            yl = yl_c;
            yh = yh_c;
        end
    end

    assign cell_idx = ADDR_W'(r_a_item.out_row) * ADDR_W'(GRID_WIDTH)
                    + ADDR_W'(r_a_item.out_col);

    // command build
    always_comb begin
        o_cmd.is_load      = a_load;
        o_cmd.value        = r_a_item.entry_value;
        o_cmd.frac_x       = r_a_x[15:0];
        o_cmd.frac_y       = r_a_y[15:0];
        o_cmd.sample_index = cell_idx[7:0];
        o_cmd.addr_b = ADDR_W'(yl) * ADDR_W'(GRID_WIDTH) + ADDR_W'(xh);
        o_cmd.addr_c = ADDR_W'(yh) * ADDR_W'(GRID_WIDTH) + ADDR_W'(xl);
        o_cmd.addr_d = ADDR_W'(yh) * ADDR_W'(GRID_WIDTH) + ADDR_W'(xh);
        if (a_load) begin
            o_cmd.addr_a = ADDR_W'(r_a_item.entry_index);
        end else begin
            o_cmd.addr_a = ADDR_W'(yl) * ADDR_W'(GRID_WIDTH) + ADDR_W'(xl);
        end
    end

    assign o_push = r_a_valid && !drop && !i_q_full;

endmodule

// ===== design/gbr_back.sv =====
// Back end: runs commands against the gain store, reads four neighbors per
// sample, blends them and buffers results. Uses gbr_pkg and gbr_ram.
module gbr_back #(
    parameter int unsigned GRID_WIDTH  = 16,
    parameter int unsigned GRID_HEIGHT = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  gbr_pkg::t_cmd      i_q_cmd,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gbr_pkg::t_out_item o_out_data
);
    import gbr_pkg::*;

    localparam int unsigned CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int unsigned AW    = $clog2(CELLS);

    t_bk_state         r_state, n_state;
    logic [1:0]        r_used;
    logic              credit_ok;
    logic              start;
    logic              issue;
    t_tap              issue_tap;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [15:0]       ram_rdata;
    logic              out_accept;

    assign credit_ok = (r_used < 2'd2);

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid && !i_q_cmd.is_load && credit_ok) begin
                    n_state = BK_RD1;
                end
            end
            BK_RD1:  n_state = BK_RD2;
            BK_RD2:  n_state = BK_RD3;
            BK_RD3:  n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = i_q_cmd.addr_a;
        o_q_pop   = 1'b0;
        issue     = 1'b0;
        issue_tap = TAP_A;
        start     = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid && i_q_cmd.is_load) begin
                    ram_we  = 1'b1;
                    o_q_pop = 1'b1;
                end else if (i_q_valid && credit_ok) begin
                    issue = 1'b1;
                    start = 1'b1;
                end
            end
            BK_RD1: begin
                ram_addr  = i_q_cmd.addr_b;
                issue     = 1'b1;
                issue_tap = TAP_B;
            end
            BK_RD2: begin
                ram_addr  = i_q_cmd.addr_c;
                issue     = 1'b1;
                issue_tap = TAP_C;
            end
            BK_RD3: begin
                ram_addr  = i_q_cmd.addr_d;
                issue     = 1'b1;
                issue_tap = TAP_D;
                o_q_pop   = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    gbr_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr[AW-1:0]),
        .i_wdata (i_q_cmd.value),
        .o_rdata (ram_rdata)
    );

    // read stage: tags travel with the RAM access
    logic        r_d_valid;
    t_tap        r_d_tap;
    logic [15:0] r_d_fx;
    logic [15:0] r_d_fy;
    logic [7:0]  r_d_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_d_tap <= issue_tap;
            r_d_fx  <= i_q_cmd.frac_x;
            r_d_fy  <= i_q_cmd.frac_y;
            r_d_idx <= i_q_cmd.sample_index;
        end
    end

    // row blends and the upper half of the column blend
    logic [16:0] w_x;
    logic [16:0] w_fy_inv;
    logic [32:0] row_prod;
    logic [31:0] r_row;
    logic [31:0] r_above;
    logic [31:0] r_below;
    logic [48:0] r_colp;
    logic        r_f_valid;
    logic [15:0] r_f_fy;
    logic [7:0]  r_f_idx;

    always_comb begin
        if (r_d_tap == TAP_A || r_d_tap == TAP_C) begin
            w_x = FRAC_ONE - {1'b0, r_d_fx};
        end else begin
            w_x = {1'b0, r_d_fx};
        end
    end

    assign row_prod = 33'(ram_rdata) * 33'(w_x);
    assign w_fy_inv = FRAC_ONE - {1'b0, r_d_fy};

    always_ff @(posedge i_clk) begin
        if (r_d_valid) begin
            case (r_d_tap)
                TAP_A: r_row <= row_prod[31:0];
                TAP_B: r_above <= r_row + row_prod[31:0];
                TAP_C: begin
                    r_row  <= row_prod[31:0];
                    r_colp <= 49'(r_above) * 49'(w_fy_inv);
                end
                TAP_D: begin
                    r_below <= r_row + row_prod[31:0];
                    r_f_fy  <= r_d_fy;
                    r_f_idx <= r_d_idx;
                end
                default: r_row <= r_row;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else begin
            r_f_valid <= r_d_valid && (r_d_tap == TAP_D);
        end
    end

    // final blend, truncated to Q4.12
    logic [48:0] col_sum;
    t_out_item   fin_item;

    assign col_sum = r_colp + 49'(r_below) * 49'(r_f_fy);
    assign fin_item.sample_value = col_sum[47:32];
    assign fin_item.sample_index = r_f_idx;

    // two-entry result buffer; credits keep it from overflowing
    t_out_item  r_of_slot [2];
    logic       r_of_wp;
    logic       r_of_rp;
    logic [1:0] r_of_cnt;

    assign o_out_valid = (r_of_cnt != 2'd0);
    assign o_out_data  = r_of_slot[r_of_rp];
    assign out_accept  = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_of_wp  <= 1'b0;
            r_of_rp  <= 1'b0;
            r_of_cnt <= 2'd0;
            r_used   <= 2'd0;
        end else begin
            r_of_wp  <= r_of_wp ^ r_f_valid;
            r_of_rp  <= r_of_rp ^ out_accept;
            r_of_cnt <= r_of_cnt + {1'b0, r_f_valid} - {1'b0, out_accept};
            r_used   <= r_used + {1'b0, start} - {1'b0, out_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_f_valid) begin
            r_of_slot[r_of_wp] <= fin_item;
        end
    end

endmodule

// ===== design/gain_grid_bilinear_resampler_core.sv =====
// Top level of the gain grid bilinear resampler: configuration registers,
// front end, command queue and back end. Depends on gbr_pkg and submodules.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes load and
//   sample requests; a transfer happens when valid is high and stall low.
//   A load writes one gain entry; a load past the grid is dropped. A sample
//   request returns one result on the output channel (o_out_valid /
//   i_out_stall / o_out_data), in request order.
//   Each sample makes four neighbor reads on the gain store's single port,
//   a load one write; the next command waits for those reads. A sample
//   passes stage A, the queue, the RAM read, the blend registers and the
//   output buffer. The front end keeps taking requests into a two-entry
//   command queue while the back end works; results wait in a two-entry
//   output buffer, and a stalled receiver holds back new samples only once
//   that buffer is spoken for. The user must write configuration over the
//   APB-style port only while the block is idle; the block does not
//   enforce this. Reset (synchronous, active low) empties all queues and
//   restores the register defaults; gain entries are undefined until loaded.
module gain_grid_bilinear_resampler_core #(
    parameter int unsigned GRID_WIDTH  = 16,
    parameter int unsigned GRID_HEIGHT = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  gbr_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gbr_pkg::t_out_item o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import gbr_pkg::*;

    t_cfg r_cfg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_start         <= 24'd0;
            r_cfg.x_step          <= 21'd65536;
            r_cfg.y_start         <= 24'd0;
            r_cfg.y_step          <= 21'd65536;
            r_cfg.flip_horizontal <= 1'b0;
            r_cfg.flip_vertical   <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_X_START: r_cfg.x_start         <= pwdata[23:0];
                REG_X_STEP:  r_cfg.x_step          <= pwdata[20:0];
                REG_Y_START: r_cfg.y_start         <= pwdata[23:0];
                REG_Y_STEP:  r_cfg.y_step          <= pwdata[20:0];
                REG_FLIP_H:  r_cfg.flip_horizontal <= pwdata[0];
                REG_FLIP_V:  r_cfg.flip_vertical   <= pwdata[0];
                default:     r_cfg <= r_cfg;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (paddr[4:2])
            REG_X_START: prdata = {8'd0, r_cfg.x_start};
            REG_X_STEP:  prdata = {11'd0, r_cfg.x_step};
            REG_Y_START: prdata = {8'd0, r_cfg.y_start};
            REG_Y_STEP:  prdata = {11'd0, r_cfg.y_step};
            REG_FLIP_H:  prdata = {31'd0, r_cfg.flip_horizontal};
            REG_FLIP_V:  prdata = {31'd0, r_cfg.flip_vertical};
            default:     prdata = 32'd0;
        endcase
    end

    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    gbr_front #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .i_q_full   (q_full)
    );

    gbr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    gbr_back #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== dv/tb.sv =====
// Self-checking bench for gain_grid_bilinear_resampler_core: random loads and samples
// against a bit-exact bilinear predictor, under bursty input and stalling output.
// Depends on gbr_pkg and the core RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gbr_pkg::*;

    localparam int GRID_W   = 16;
    localparam int GRID_H   = 12;
    localparam int CELLS    = GRID_W * GRID_H;
    localparam int LAT_PAD  = 12;   // settle time past the last result
    localparam int N_PHASES = 7;
    localparam int PHASE_N  = 100;
    localparam int HOLD_LEN = 300;

    // DUT-facing signals
    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_item    in_data = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state
    logic [15:0] gain_copy [CELLS];
    t_cfg        cfg_shadow;
    t_in_item    pending_reqs [$];
    t_out_item   expected_results [$];
    t_out_item   want_result;
    int          err_count = 0;

    // Traffic shaping knobs, set per phase
    int tx_gap_max = 0;
    int rx_stall_max = 0;
    int burst_left = 0;
    int gap_left = 0;
    int rx_run = 0;
    bit rx_stalling = 1'b0;
    int hold_req_cnt = 0;
    int hold_served = 0;
    int hold_left = 0;

    gain_grid_bilinear_resampler_core #(
        .GRID_WIDTH  (GRID_W),
        .GRID_HEIGHT (GRID_H)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("** gain_grid_bilinear_resampler_core: FAILED **");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        err_count++;
    endtask

    // Floor/fraction split, clamp to the table edge, then optional mirror
    function automatic void split_axis(input longint pos, input int size, input logic flip,
                                       output int lo, output int hi,
                                       output longint unsigned frac);
        longint base;
        int     last;
        frac = longint'(unsigned'(pos[15:0]));
        base = pos >>> 16;
        last = size - 1;
        lo = (base < 0) ? 0 : (base > last) ? last : int'(base);
        hi = (base + 1 < 0) ? 0 : (base + 1 > last) ? last : int'(base + 1);
        if (flip) begin
            lo = last - lo;
            hi = last - hi;
        end
    endfunction

    function automatic t_out_item predict_sample(input t_in_item req);
        longint            xpos, ypos;
        int                xl, xh, yl, yh;
        longint unsigned   fx, fy, above, below, blend;
        t_out_item         res;
        xpos = longint'($signed(cfg_shadow.x_start))
             + longint'(req.out_col) * longint'(cfg_shadow.x_step);
        ypos = longint'($signed(cfg_shadow.y_start))
             + longint'(req.out_row) * longint'(cfg_shadow.y_step);
        split_axis(xpos, GRID_W, cfg_shadow.flip_horizontal, xl, xh, fx);
        split_axis(ypos, GRID_H, cfg_shadow.flip_vertical, yl, yh, fy);
        above = longint'(unsigned'(gain_copy[yl * GRID_W + xl])) * (64'd65536 - fx)
              + longint'(unsigned'(gain_copy[yl * GRID_W + xh])) * fx;
        below = longint'(unsigned'(gain_copy[yh * GRID_W + xl])) * (64'd65536 - fx)
              + longint'(unsigned'(gain_copy[yh * GRID_W + xh])) * fx;
        blend = (above * (64'd65536 - fy) + below * fy) >> 32;
        res.sample_value = 16'(blend);
        res.sample_index = 8'(int'(req.out_row) * GRID_W + int'(req.out_col));
        return res;
    endfunction

    // Update the gain copy or queue the expected sample for one accepted transfer
    function automatic void predict_request(input t_in_item req);
        if (req.req_type == REQ_LOAD) begin
            if (int'(req.entry_index) < CELLS)
                gain_copy[req.entry_index] = req.entry_value;
        end else begin
            expected_results.insert(expected_results.size(), predict_sample(req));
        end
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_in_item make_random_request();
        t_in_item r;
        r.entry_index = 8'($urandom_range(0, 255));
        r.entry_value = pick_gain();
        r.out_col     = 4'($urandom_range(0, 15));
        r.out_row     = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 99) < 35) begin
            r.req_type = REQ_LOAD;
            // mostly in-grid loads, a few at any index, some of them dropped past the end
            if ($urandom_range(0, 9) != 0)
                r.entry_index = 8'($urandom_range(0, CELLS - 1));
        end else begin
            r.req_type = REQ_SAMPLE;
            if ($urandom_range(0, 5) != 0)
                r.out_row = 4'($urandom_range(0, GRID_H - 1));
        end
        return r;
    endfunction

    function automatic t_in_item make_load(input int idx, input logic [15:0] val);
        t_in_item r;
        r = '0;
        r.req_type    = REQ_LOAD;
        r.entry_index = 8'(idx);
        r.entry_value = val;
        r.out_col     = 4'($urandom_range(0, 15));
        r.out_row     = 4'($urandom_range(0, 15));
        return r;
    endfunction

    function automatic t_in_item make_sample(input int col, input int row);
        t_in_item r;
        r = '0;
        r.req_type    = REQ_SAMPLE;
        r.entry_index = 8'($urandom_range(0, 255));
        r.entry_value = 16'($urandom_range(0, 65535));
        r.out_col     = 4'(col);
        r.out_row     = 4'(row);
        return r;
    endfunction

    // Append one request to the driver's pending list
    function automatic void add_req(input t_in_item r);
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    // Fixed extreme settings first, then random ones around the table
    function automatic t_cfg phase_cfg(input int p);
        t_cfg c;
        case (p)
            0: c = '{24'h008000, 21'h008000, 24'h004000, 21'h00C000, 1'b0, 1'b0};
            1: c = '{24'h800000, 21'h100000, 24'h7FFFFF, 21'h000000, 1'b1, 1'b0};
            2: c = '{24'h7FFFFF, 21'h000000, 24'h800000, 21'h1FFFFF, 1'b0, 1'b1};
            default: begin
                c.x_start = 24'(int'($urandom_range(0, 20 * 65536)) - 4 * 65536);
                c.y_start = 24'(int'($urandom_range(0, 16 * 65536)) - 4 * 65536);
                c.x_step  = 21'($urandom_range(0, 2 * 65536));
                c.y_step  = 21'($urandom_range(0, 2 * 65536));
                c.flip_horizontal = 1'($urandom_range(0, 1));
                c.flip_vertical   = 1'($urandom_range(0, 1));
                if (p == N_PHASES - 1) begin
                    c.x_start = 24'($urandom());
                    c.x_step  = 21'($urandom_range(0, 1048576));
                end
            end
        endcase
        return c;
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_cfg(input t_cfg c);
        reg_write(REG_X_START, {{8{c.x_start[23]}}, c.x_start});
        reg_write(REG_X_STEP, {11'd0, c.x_step});
        reg_write(REG_Y_START, {{8{c.y_start[23]}}, c.y_start});
        reg_write(REG_Y_STEP, {11'd0, c.y_step});
        reg_write(REG_FLIP_H, {31'd0, c.flip_horizontal});
        reg_write(REG_FLIP_V, {31'd0, c.flip_vertical});
        cfg_shadow = c;
    endtask

    // Block until every queued item is sent and every sample has come back
    task automatic wait_idle(input int settle);
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (settle) @(negedge i_clk);
    endtask

    // Input driver: bursts of transfers with random gaps, payload held while stalled
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (in_valid && !o_in_stall)
                predict_request(in_data);
            if (!in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_reqs.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output stall: alternating runs, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (hold_served != hold_req_cnt) begin
            hold_served = hold_req_cnt;
            hold_left = HOLD_LEN;
            out_stall <= 1'b1;
        end else if (rx_stall_max == 0) begin
            out_stall <= 1'b0;
        end else begin
            if (rx_run > 0) begin
                rx_run--;
            end else begin
                rx_stalling = !rx_stalling;
                rx_run = rx_stalling ? $urandom_range(1, rx_stall_max) : $urandom_range(1, 8);
            end
            out_stall <= rx_stalling;
        end
    end

    // Result monitor: compare each output transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result value=%h index=%0d",
                                          o_out_data.sample_value, o_out_data.sample_index));
            end else begin
                want_result = expected_results.pop_front();
                if (o_out_data.sample_value !== want_result.sample_value)
                    report_mismatch($sformatf("sample_value %h, want %h (index %0d)",
                                              o_out_data.sample_value,
                                              want_result.sample_value,
                                              want_result.sample_index));
                if (o_out_data.sample_index !== want_result.sample_index)
                    report_mismatch($sformatf("sample_index %0d, want %0d",
                                              o_out_data.sample_index,
                                              want_result.sample_index));
            end
        end
    end

    // Stimulus sequence
    initial begin
        int fill_order [CELLS];
        int j, tmp;
        cfg_shadow = '{24'd0, 21'h010000, 24'd0, 21'h010000, 1'b0, 1'b0};
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // Fill every entry once, in shuffled order, so no sample reads an unwritten cell
        tx_gap_max = 3;
        rx_stall_max = 3;
        for (int i = 0; i < CELLS; i++) fill_order[i] = i;
        for (int i = CELLS - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = fill_order[i];
            fill_order[i] = fill_order[j];
            fill_order[j] = tmp;
        end
        for (int i = 0; i < CELLS; i++)
            add_req(make_load(fill_order[i], pick_gain()));

        // Directed: gain extremes, dropped loads, corner cells, rows past the grid
        add_req(make_load(0, 16'hFFFF));
        add_req(make_load(CELLS - 1, 16'h0000));
        add_req(make_load(CELLS, 16'h1234));
        add_req(make_load(255, 16'hFFFF));
        add_req(make_sample(0, 0));
        add_req(make_sample(GRID_W - 1, GRID_H - 1));
        add_req(make_sample(15, 15));
        add_req(make_sample(3, 12));
        add_req(make_sample(0, 15));

        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle(LAT_PAD);
            apply_cfg(phase_cfg(p));
            tx_gap_max   = (p % 3 == 0) ? 0 : $urandom_range(1, 8);
            rx_stall_max = (p % 3 == 1) ? 0 : $urandom_range(1, 12);
            add_req(make_sample(0, 0));
            add_req(make_sample(GRID_W - 1, GRID_H - 1));
            for (int i = 0; i < PHASE_N / 2; i++)
                add_req(make_random_request());
            // sender pauses until all results are back, then resumes
            if (p == 2) wait_idle(0);
            for (int i = PHASE_N / 2; i < PHASE_N; i++)
                add_req(make_random_request());
            // long receiver hold-off while the sender keeps offering
            if (p == 3 || p == 5) hold_req_cnt++;
        end

        wait_idle(LAT_PAD);
        if (err_count == 0 && expected_results.size() == 0) begin
            $display("** gain_grid_bilinear_resampler_core: PASSED **");
        end else begin
            $display("** gain_grid_bilinear_resampler_core: FAILED **");
        end
        $finish;
    end

endmodule
